FILE: rtl/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

	// Default width of the tick counters.
	localparam int TICK_BITS_DEFAULT = 16;

	// Register file geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int HELD_W     = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_DATA_W-1:0] SHORT_RST    = 16'd500;
	localparam logic [CFG_DATA_W-1:0] LONG_RST     = 16'd1000;

	// Timing settings as seen by the classifier.
	typedef struct packed {
		logic [CFG_DATA_W-1:0] debounce_ticks;
		logic [CFG_DATA_W-1:0] short_press_ticks;
		logic [CFG_DATA_W-1:0] long_press_ticks;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic              press_event;
		logic              release_event;
		logic              short_press_event;
		logic              long_press_event;
		logic              is_held;
		logic [HELD_W-1:0] held_ticks;
	} result_t;

endpackage

FILE: rtl/button_debounce_press_classifier.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// input     in_valid / in_stall         raw_level
// output    out_valid / out_stall       press_event .. held_ticks
// config    cfg_we (no handshake back)  cfg_index, cfg_data
//
// One beat in gives one beat out, from the result register.
// A new beat is taken every cycle while in_stall is low; the classifier state updates in one pass.
// in_stall rises only while a result waits and out_stall holds it.
// Reset leaves the button released, counters at zero and default timings.

module button_debounce_press_classifier
	import bdpc_pkg::*;
#(
	parameter int TICK_COUNTER_BITS = TICK_BITS_DEFAULT
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  raw_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  press_event,
	output logic                  release_event,
	output logic                  short_press_event,
	output logic                  long_press_event,
	output logic                  is_held,
	output logic [HELD_W-1:0]     held_ticks,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    take;

	bdpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdpc_core #(
		.TICK_COUNTER_BITS (TICK_COUNTER_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.raw_level (raw_level),
		.cfg       (cfg),
		.result    (result)
	);

	// Input waits only while the result register is full and held.
	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result;
		end
	end

	assign out_valid         = out_valid_q;
	assign press_event       = result_q.press_event;
	assign release_event     = result_q.release_event;
	assign short_press_event = result_q.short_press_event;
	assign long_press_event  = result_q.long_press_event;
	assign is_held           = result_q.is_held;
	assign held_ticks        = result_q.held_ticks;

endmodule

FILE: rtl/bdpc_cfg.sv
`timescale 1ns / 1ps

module bdpc_cfg
	import bdpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEBOUNCE_RST;
			cfg_q.short_press_ticks <= SHORT_RST;
			cfg_q.long_press_ticks  <= LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks    <= cfg_data;
				REG_SHORT:    cfg_q.short_press_ticks <= cfg_data;
				REG_LONG:     cfg_q.long_press_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/bdpc_core.sv
`timescale 1ns / 1ps

module bdpc_core
	import bdpc_pkg::*;
#(
	parameter int TICK_COUNTER_BITS = TICK_BITS_DEFAULT
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  logic    raw_level,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int CW = (TICK_COUNTER_BITS > CFG_DATA_W) ? TICK_COUNTER_BITS : CFG_DATA_W;
	localparam logic [TICK_COUNTER_BITS-1:0] CNT_MAX = '1;
	localparam logic [CW-1:0] HELD_MAX = CW'({HELD_W{1'b1}});

	logic                         prev_raw_q;
	logic [TICK_COUNTER_BITS-1:0] stable_q;
	logic                         qual_q;
	logic [TICK_COUNTER_BITS-1:0] press_q;
	logic                         long_fired_q;

	logic                         prev_raw_d;
	logic [TICK_COUNTER_BITS-1:0] stable_d;
	logic                         qual_d;
	logic [TICK_COUNTER_BITS-1:0] press_d;
	logic                         long_fired_d;
	logic                         steady;
	logic [CW-1:0]                press_ext;

	// Next state and result for the beat at the input.
	always_comb begin
		result       = '0;
		prev_raw_d   = raw_level;
		qual_d       = qual_q;
		long_fired_d = long_fired_q;

		// Ticks since the raw level last changed.
		if (raw_level != prev_raw_q) begin
			stable_d = '0;
		end else begin
			stable_d = (stable_q == CNT_MAX) ? stable_q : stable_q + 1'b1;
		end

		// Hold time keeps counting even while the debounce blocks.
		if (!qual_q) begin
			press_d = (press_q == CNT_MAX) ? press_q : press_q + 1'b1;
		end else begin
			press_d = press_q;
		end
		press_ext = CW'(press_d);

		steady = CW'(stable_d) >= CW'(cfg.debounce_ticks);

		if (steady) begin
			if (!raw_level && qual_q) begin
				qual_d             = 1'b0;
				press_d            = '0;
				long_fired_d       = 1'b0;
				result.press_event = 1'b1;
			end else if (raw_level && !qual_q) begin
				qual_d               = 1'b1;
				result.release_event = 1'b1;
				if (!long_fired_q && (press_ext < CW'(cfg.short_press_ticks))) begin
					result.short_press_event = 1'b1;
				end
			end else if (!raw_level && !long_fired_q) begin
				if (press_ext >= CW'(cfg.long_press_ticks)) begin
					long_fired_d            = 1'b1;
					result.long_press_event = 1'b1;
				end
			end
		end

		// Reported hold time, clamped to the output width.
		press_ext      = CW'(press_d);
		result.is_held = !qual_d;
		if (!qual_d) begin
			result.held_ticks = (press_ext > HELD_MAX) ? {HELD_W{1'b1}}
			                                           : press_ext[HELD_W-1:0];
		end
	end

	// State advances once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q   <= 1'b1;
			stable_q     <= '0;
			qual_q       <= 1'b1;
			press_q      <= '0;
			long_fired_q <= 1'b0;
		end else if (take) begin
			prev_raw_q   <= prev_raw_d;
			stable_q     <= stable_d;
			qual_q       <= qual_d;
			press_q      <= press_d;
			long_fired_q <= long_fired_d;
		end
	end

endmodule

FILE: tb/sv/tb_button_debounce_press_classifier.sv
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier;
	import bdpc_pkg::*;

	// Index that no register answers to; writes to it must leave the timings alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [15:0] CNT_SAT = 16'hFFFF;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  raw_level = 1'b1;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  press_event;
	logic                  release_event;
	logic                  short_press_event;
	logic                  long_press_event;
	logic                  is_held;
	logic [HELD_W-1:0]     held_ticks;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	button_debounce_press_classifier dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.raw_level         (raw_level),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.press_event       (press_event),
		.release_event     (release_event),
		.short_press_event (short_press_event),
		.long_press_event  (long_press_event),
		.is_held           (is_held),
		.held_ticks        (held_ticks),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Shadow copy of the timing registers and the classifier state.
	cfg_t        timing = '{DEBOUNCE_RST, SHORT_RST, LONG_RST};
	logic        prev_raw = 1'b1;
	logic [15:0] stable_cnt = '0;
	logic        btn_level = 1'b1;
	logic [15:0] hold_cnt = '0;
	logic        long_done = 1'b0;

	logic    raw_pending[$];
	result_t tick_results[$];
	int      beats_queued = 0;
	int      beats_taken = 0;
	int      mismatches = 0;
	int      random_beats = 0;
	logic    in_took = 1'b0;
	logic    no_idle = 1'b0;
	logic    last_level = 1'b1;
	int      burst_left = 1;
	int      gap_left = 0;
	int      stall_left = 0;
	int      free_left = 0;

	// Advances the shadow state by one tick and returns the flags it raises.
	function automatic result_t classify_tick(input logic raw);
		result_t r;
		r = '0;
		if (raw != prev_raw) begin
			stable_cnt = '0;
		end else if (stable_cnt != CNT_SAT) begin
			stable_cnt = stable_cnt + 16'd1;
		end
		prev_raw = raw;
		// Hold time runs even while the debounce blocks the level.
		if (!btn_level && hold_cnt != CNT_SAT) begin
			hold_cnt = hold_cnt + 16'd1;
		end
		if (stable_cnt >= timing.debounce_ticks) begin
			if (!raw && btn_level) begin
				btn_level = 1'b0;
				hold_cnt = '0;
				long_done = 1'b0;
				r.press_event = 1'b1;
			end else if (raw && !btn_level) begin
				btn_level = 1'b1;
				r.release_event = 1'b1;
				r.short_press_event = !long_done && (hold_cnt < timing.short_press_ticks);
			end else if (!raw && !long_done && hold_cnt >= timing.long_press_ticks) begin
				long_done = 1'b1;
				r.long_press_event = 1'b1;
			end
		end
		r.is_held = !btn_level;
		r.held_ticks = btn_level ? '0 : hold_cnt;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Output beats are checked before this edge's input beat is predicted,
	// since a result is registered and so always trails its input.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (tick_results.size() == 0) begin
					$display("%0t: result beat expected none actual held_ticks %0h",
						$time, held_ticks);
					mismatches++;
				end else begin
					want = tick_results.pop_front();
					check_field("press_event", want.press_event, press_event);
					check_field("release_event", want.release_event, release_event);
					check_field("short_press_event", want.short_press_event,
						short_press_event);
					check_field("long_press_event", want.long_press_event, long_press_event);
					check_field("is_held", want.is_held, is_held);
					check_field("held_ticks", want.held_ticks, held_ticks);
				end
			end
			if (in_valid && !in_stall) begin
				tick_results.push_back(classify_tick(raw_level));
				beats_taken++;
			end
			in_took <= in_valid && !in_stall;
		end
	end

	// Sender: bursts of beats separated by random gaps; a beat holds until taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (gap_left > 0 && !no_idle) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (raw_pending.size() > 0) begin
				raw_level <= raw_pending.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall runs alternate with free runs, some of them long.
	always @(negedge clk) begin
		if (!arst_n || no_idle) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (free_left > 0) begin
			out_stall <= 1'b0;
			free_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = $urandom_range(1, 5);
			free_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 10);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_DEBOUNCE: timing.debounce_ticks = val;
			REG_SHORT:    timing.short_press_ticks = val;
			REG_LONG:     timing.long_press_ticks = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_run(input logic lvl, input int n);
		repeat (n) raw_pending.push_back(lvl);
		beats_queued += n;
		last_level = lvl;
	endtask

	// Waits until every queued beat has been taken and its result checked.
	task automatic drain();
		while (raw_pending.size() != 0 || beats_taken != beats_queued ||
				tick_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_timing(input int hi);
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 16'd0;
		else if (k == 9)
			return CNT_SAT;
		return 16'($urandom_range(1, hi));
	endfunction

	// Mostly level runs long enough to qualify, with bounces and single-tick noise.
	task automatic random_phase(input int n_items);
		int made;
		int settle;
		int kind;
		int len;
		made = 0;
		settle = (timing.debounce_ticks > 16'd200) ? 0 : int'(timing.debounce_ticks);
		while (made < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				len = 1;
				push_run(1'($urandom_range(0, 1)), len);
			end else if (kind <= 2) begin
				len = $urandom_range(1, settle + 1);
				push_run(!last_level, len);
			end else begin
				len = settle + $urandom_range(0, 70);
				if (len == 0)
					len = 1;
				push_run(!last_level, len);
			end
			made += len;
		end
		random_beats += made;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset timings: short bounces never qualify.
		@(posedge clk);
		push_run(1'b0, 3);
		push_run(1'b1, 2);
		push_run(1'b0, 3);
		drain();

		// Zero debounce, zero short and zero long times; the spare index is ignored.
		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_SHORT, 16'd0);
		write_reg(REG_LONG, 16'd0);
		write_reg(REG_SPARE, CNT_SAT);
		@(posedge clk);
		push_run(1'b1, 1);
		push_run(1'b0, 3);
		push_run(1'b1, 2);
		push_run(1'b0, 1);
		push_run(1'b1, 1);
		drain();

		// Small timings: a press held too long to count as short, then a press that turns long.
		write_reg(REG_DEBOUNCE, 16'd2);
		write_reg(REG_SHORT, 16'd3);
		write_reg(REG_LONG, 16'd5);
		@(posedge clk);
		push_run(1'b0, 3);
		push_run(1'b1, 3);
		push_run(1'b0, 9);
		push_run(1'b1, 3);
		drain();

		// Random timings per phase, extremes included.
		while (random_beats < 950) begin
			write_reg(REG_DEBOUNCE, pick_timing(6));
			write_reg(REG_SHORT, pick_timing(40));
			write_reg(REG_LONG, pick_timing(60));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
			@(posedge clk);
			random_phase($urandom_range(60, 120));
			drain();
		end

		// Full-scale timings: a short steady level never qualifies, with no idling; then zero debounce.
		no_idle = 1'b1;
		write_reg(REG_DEBOUNCE, CNT_SAT);
		write_reg(REG_SHORT, CNT_SAT);
		write_reg(REG_LONG, CNT_SAT);
		@(posedge clk);
		push_run(1'b1, 2);
		push_run(1'b0, 40);
		drain();
		write_reg(REG_DEBOUNCE, 16'd0);
		@(posedge clk);
		push_run(1'b1, 2);
		push_run(1'b0, 2);
		push_run(1'b1, 2);
		drain();
		no_idle = 1'b0;

		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
